// ----- hw/rtl/maf_pkg.sv -----
// ----------------------------------------------------------------------------
// Moving average filter package
// Shared widths, defaults, command codes, control structs and the window clamp.
// ----------------------------------------------------------------------------
package maf_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int CNT_W          = 7;
    localparam int MAX_WINDOW_DEF = 64;
    localparam int WINDOW_RESET   = 8;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic clear;
        logic push;
        logic update;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_status;

    function automatic logic [CNT_W-1:0] clamp_window(input logic [CNT_W-1:0] value,
                                                      input int max_window);
        logic [CNT_W-1:0] result;
        if (value == '0) begin
            result = CNT_W'(1);
        end else if (int'(value) > max_window) begin
            result = CNT_W'(max_window);
        end else begin
            result = value;
        end
        return result;
    endfunction

endpackage

// ----- hw/rtl/maf_in_if.sv -----
// ----------------------------------------------------------------------------
// Moving average filter input channel
// Valid/ready channel carrying a command and a signed sample.
// ----------------------------------------------------------------------------
interface maf_in_if import maf_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink   (input valid, input cmd, input sample, output ready);

endinterface

// ----- hw/rtl/maf_out_if.sv -----
// ----------------------------------------------------------------------------
// Moving average filter output channel
// Valid/ready channel carrying the mean and the held sample count.
// ----------------------------------------------------------------------------
interface maf_out_if import maf_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] mean;
    logic [CNT_W-1:0]           held_count;

    modport source (output valid, output mean, output held_count, input ready);
    modport sink   (input valid, input mean, input held_count, output ready);

endinterface

// ----- hw/rtl/maf_ctrl.sv -----
// ----------------------------------------------------------------------------
// Moving average filter controller
// Sequences one transaction: a clear in the idle state, or a push through window update, divider setup, divide, output.
// ----------------------------------------------------------------------------
module maf_ctrl import maf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_cmd,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UPDATE = 5'b00010,
        S_PREP   = 5'b00100,
        S_DIV    = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_accept;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in_cmd == CMD_CLEAR) begin
                        o_cmd.clear = 1'b1;
                    end else begin
                        o_cmd.push = 1'b1;
                        n_state    = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_PREP;
            end
            S_PREP: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- hw/rtl/maf_datapath.sv -----
// ----------------------------------------------------------------------------
// Moving average filter datapath
// Sample ring, running sum, fill count, restoring divider and output register.
// ----------------------------------------------------------------------------
module maf_datapath import maf_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CNT_W-1:0]           i_cfg_wdata,
    input  t_dp_cmd                    i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output t_dp_status                 o_status,
    output logic signed [SAMPLE_W-1:0] o_mean,
    output logic [CNT_W-1:0]           o_held_count
);

    localparam int SUM_W   = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CMP_W   = (SLOT_W + 1 > CNT_W) ? SLOT_W + 1 : CNT_W;
    localparam int DIV_CW  = $clog2(SUM_W);
    localparam int WIN_RST = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

    logic [SAMPLE_W-1:0]        r_ring [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] r_old;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic [SLOT_W-1:0]          r_slot, n_slot;
    logic [CNT_W-1:0]           r_fill, n_fill;
    logic [CNT_W-1:0]           r_window;
    logic [SUM_W-1:0]           r_quo;
    logic [CNT_W-1:0]           r_rem;
    logic                       r_neg;
    logic [DIV_CW-1:0]          r_div_cnt;
    logic signed [SAMPLE_W-1:0] r_mean;
    logic [CNT_W-1:0]           r_held;

    logic                       full;
    logic [SLOT_W:0]            slot_inc;
    logic [CNT_W:0]             trial;
    logic                       trial_ge;
    logic [SUM_W-1:0]           quo_signed;

    assign full     = (r_fill >= r_window);
    assign slot_inc = {1'b0, r_slot} + (SLOT_W + 1)'(1);

    always_comb begin
        n_sum  = r_sum + SUM_W'(r_sample);
        n_fill = r_fill;
        if (full) begin
            n_sum = n_sum - SUM_W'(r_old);
        end else begin
            n_fill = r_fill + CNT_W'(1);
        end
        if (CMP_W'(slot_inc) >= CMP_W'(r_window)) begin
            n_slot = '0;
        end else begin
            n_slot = slot_inc[SLOT_W-1:0];
        end
    end

    assign trial      = {r_rem, r_quo[SUM_W-1]};
    assign trial_ge   = (trial >= {1'b0, r_fill});
    assign quo_signed = r_neg ? (SUM_W'(0) - r_quo) : r_quo;

    assign o_status.div_last = (r_div_cnt == '0);
    assign o_mean            = r_mean;
    assign o_held_count      = r_held;

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= CNT_W'(WIN_RST);
            r_sum    <= '0;
            r_slot   <= '0;
            r_fill   <= '0;
        end else if (i_cfg_we) begin
            r_window <= clamp_window(i_cfg_wdata, MAX_WINDOW);
            r_sum    <= '0;
            r_slot   <= '0;
            r_fill   <= '0;
        end else if (i_cmd.clear) begin
            r_sum    <= '0;
            r_slot   <= '0;
            r_fill   <= '0;
        end else if (i_cmd.update) begin
            r_sum    <= n_sum;
            r_slot   <= n_slot;
            r_fill   <= n_fill;
        end
    end

    // sample ring
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_sample <= i_sample;
            r_old    <= signed'(r_ring[r_slot]);
        end
        if (i_cmd.update) begin
            r_ring[r_slot] <= r_sample;
        end
    end

    // restoring divider on the sum magnitude
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg     <= r_sum[SUM_W-1];
            r_quo     <= r_sum[SUM_W-1] ? (SUM_W'(0) - r_sum) : r_sum;
            r_rem     <= '0;
            r_div_cnt <= DIV_CW'(SUM_W - 1);
        end else if (i_cmd.div_step) begin
            r_quo     <= {r_quo[SUM_W-2:0], trial_ge};
            r_rem     <= trial_ge ? CNT_W'(trial - {1'b0, r_fill}) : trial[CNT_W-1:0];
            r_div_cnt <= r_div_cnt - DIV_CW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_mean <= signed'(quo_signed[SAMPLE_W-1:0]);
            r_held <= r_fill;
        end
    end

endmodule

// ----- hw/rtl/moving_average_filter.sv -----
// ----------------------------------------------------------------------------
// Moving average filter
// Running mean of signed 16-bit samples over a programmable window.
// ----------------------------------------------------------------------------
// Input channel (valid/ready): cmd 0 pushes sample and yields one result,
// cmd 1 clears the window and yields none. Output channel (valid/ready):
// mean (sum / held_count, truncated toward zero) and held_count.
// i_cfg_we writes window_length; the value clamps to 1..MAX_WINDOW and the
// window state clears. Write only while the block is idle.
// A push runs through update, divider setup, the divide and the output
// load before the next transaction is accepted; the result and the next
// ready show together. The bit-serial restoring divider produces one
// quotient bit per cycle over SUM_W = 16 + log2(MAX_WINDOW) bits.
// A clear leaves the block idle and ready.
// A finished result waits in the output register, and the next transaction
// is accepted and processed meanwhile; it stalls only at its own output
// step while the receiver holds ready low.
// Reset (synchronous, active low) empties the window and sets the length
// to 8. Ring entries are not cleared; only written slots are ever read.
// ----------------------------------------------------------------------------
module moving_average_filter import maf_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    maf_in_if.sink           i_sample_ch,
    maf_out_if.source        o_mean_ch
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    maf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample_ch.valid),
        .i_in_cmd    (i_sample_ch.cmd),
        .o_in_ready  (i_sample_ch.ready),
        .o_out_valid (o_mean_ch.valid),
        .i_out_ready (o_mean_ch.ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    maf_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (dp_cmd),
        .i_sample     (i_sample_ch.sample),
        .o_status     (dp_status),
        .o_mean       (o_mean_ch.mean),
        .o_held_count (o_mean_ch.held_count)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Moving average filter testbench
// Sends push and clear transactions with random bursts and output stalls.
// Every transaction updates a local model of the window, and each result is
// checked against that model. Window writes go in only when the block is
// idle. Directed tests cover the sample extremes, clears and the window
// clamp. Random phases follow with changing windows, full-scale sums and
// frequent clears.
// ----------------------------------------------------------------------------
module tb_top import maf_pkg::*; ();

    localparam int   CLK_HALF       = 4;
    localparam int   RESET_CYCLES   = 6;
    localparam int   SETTLE_CYCLES  = 40;
    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   WIN_MAX        = MAX_WINDOW_DEF;
    localparam int   MAX_REPORTS    = 50;

    typedef struct {
        logic signed [SAMPLE_W-1:0] mean;
        logic [CNT_W-1:0]           held_count;
    } t_mean_result;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;

    maf_in_if  sample_ch ();
    maf_out_if mean_ch ();

    moving_average_filter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_sample_ch (sample_ch),
        .o_mean_ch   (mean_ch)
    );

    logic signed [SAMPLE_W-1:0] win_ring [WIN_MAX];
    int                         win_sum    = 0;
    int                         win_slot   = 0;
    int                         win_fill   = 0;
    int                         win_len    = WINDOW_RESET;
    t_mean_result               pending_means [$];

    int err_count   = 0;
    int idle_cycles = 0;
    int gap_max     = 0;
    int burst_left  = 0;
    int stall_max   = 0;

    always #CLK_HALF clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
        end
    endtask

    task automatic clear_window_model();
        win_sum  = 0;
        win_slot = 0;
        win_fill = 0;
    endtask

    task automatic predict_transaction(input logic cmd, input logic signed [SAMPLE_W-1:0] smp);
        t_mean_result res;
        if (cmd == CMD_CLEAR) begin
            clear_window_model();
        end else begin
            if (win_fill >= win_len) begin
                win_sum -= int'(win_ring[win_slot]);
            end else begin
                win_fill++;
            end
            win_ring[win_slot] = smp;
            win_sum += int'(smp);
            win_slot = (win_slot + 1 >= win_len) ? 0 : win_slot + 1;
            res.mean       = SAMPLE_W'(win_sum / win_fill);
            res.held_count = CNT_W'(win_fill);
            pending_means.push_back(res);
        end
    endtask

    // Model update on every accepted input transaction
    always @(posedge clk) begin
        if (rst_n && sample_ch.valid && sample_ch.ready) begin
            predict_transaction(sample_ch.cmd, sample_ch.sample);
        end
    end

    always @(posedge clk) begin : check_result
        t_mean_result want;
        if (rst_n && mean_ch.valid && mean_ch.ready) begin
            if (pending_means.size() == 0) begin
                report_mismatch("unexpected result, mean", mean_ch.mean, 0);
            end else begin
                want = pending_means.pop_front();
                if (mean_ch.mean !== want.mean) begin
                    report_mismatch("mean", mean_ch.mean, want.mean);
                end
                if (mean_ch.held_count !== want.held_count) begin
                    report_mismatch("held_count", mean_ch.held_count, want.held_count);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) || (mean_ch.valid && mean_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Alternate ready runs and stall runs; ready stays high while stall_max is 0
    initial begin : receiver
        int   run_left;
        logic stall;
        mean_ch.ready = 1'b0;
        run_left      = 0;
        stall         = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_max == 0) begin
                mean_ch.ready = 1'b1;
            end else begin
                if (run_left == 0) begin
                    stall    = ~stall;
                    run_left = stall ? $urandom_range(1, stall_max) : $urandom_range(1, 20);
                end
                run_left--;
                mean_ch.ready = ~stall;
            end
        end
    end

    task automatic send_transaction(input logic cmd, input logic signed [SAMPLE_W-1:0] smp);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                sample_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        sample_ch.valid  = 1'b1;
        sample_ch.cmd    = cmd;
        sample_ch.sample = smp;
        do @(posedge clk); while (!sample_ch.ready);
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        sample_ch.valid = 1'b0;
        while (pending_means.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [CNT_W-1:0] value);
        drain_pipeline();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(posedge clk);
        if (value == '0) begin
            win_len = 1;
        end else if (int'(value) > WIN_MAX) begin
            win_len = WIN_MAX;
        end else begin
            win_len = int'(value);
        end
        clear_window_model();
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic push_random(input int clear_pct);
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] smp;
        cmd = ($urandom_range(0, 99) < clear_pct) ? CMD_CLEAR : CMD_PUSH;
        if (cmd == CMD_PUSH) begin
            smp = random_sample();
        end else begin
            smp = signed'(SAMPLE_W'($urandom));
        end
        send_transaction(cmd, smp);
    endtask

    task automatic test_directed_samples();
        logic signed [SAMPLE_W-1:0] seq [9];
        seq = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0000,
                16'sh0001, 16'shFFFF, 16'sh5555, 16'shAAAA};
        gap_max   = 0;
        stall_max = 0;
        foreach (seq[k]) send_transaction(CMD_PUSH, seq[k]);
        send_transaction(CMD_CLEAR, 16'sh7FFF);
        repeat (3) send_transaction(CMD_PUSH, 16'sh8000);
        send_transaction(CMD_CLEAR, 16'sh0000);
    endtask

    task automatic test_directed_windows();
        write_window(7'd0);
        send_transaction(CMD_PUSH, 16'sh7FFF);
        send_transaction(CMD_PUSH, 16'sh8000);
        write_window(7'd127);
        send_transaction(CMD_PUSH, 16'shFFFF);
        send_transaction(CMD_PUSH, 16'sh0001);
        write_window(7'd2);
        send_transaction(CMD_PUSH, -16'sd1);
        send_transaction(CMD_PUSH, -16'sd2);
        send_transaction(CMD_PUSH, 16'sd3);
    endtask

    task automatic test_random_windows();
        int windows [6];
        int gaps    [6];
        int stalls  [6];
        windows = '{1, 64, 127, 0, int'($urandom_range(0, 127)), int'($urandom_range(1, 16))};
        gaps    = '{0, 40, 8, 40, 0, 60};
        stalls  = '{0, 0, 40, 30, 60, 5};
        foreach (windows[p]) begin
            write_window(CNT_W'(windows[p]));
            gap_max   = gaps[p];
            stall_max = stalls[p];
            repeat (250) push_random(2);
        end
    endtask

    task automatic test_full_scale_sums();
        write_window(7'd64);
        gap_max   = 20;
        stall_max = 20;
        repeat (300) begin
            send_transaction(CMD_PUSH, ($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000);
        end
        gap_max   = 0;
        stall_max = 0;
        repeat (100) send_transaction(CMD_PUSH, 16'sh8000);
    endtask

    task automatic test_clear_storm();
        write_window(CNT_W'($urandom_range(1, 12)));
        gap_max   = 40;
        stall_max = 40;
        repeat (100) push_random(25);
        write_window(7'd3);
        repeat (100) push_random(25);
    endtask

    initial begin
        sample_ch.valid  = 1'b0;
        sample_ch.cmd    = CMD_PUSH;
        sample_ch.sample = '0;
        foreach (win_ring[k]) win_ring[k] = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_directed_samples();
        test_directed_windows();
        test_random_windows();
        test_full_scale_sums();
        test_clear_storm();

        drain_pipeline();
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
